[hw/rtl/pcmv_pkg.sv]
// shared types and constants of the pcm voice playback unit
package pcmv_pkg;

   // fixed field widths
   localparam int FRAC_BITS   = 12;
   localparam int BYTE_W      = 8;
   localparam int FIELD_ADDR_W = 16;
   localparam int LEN_W       = 17;
   localparam int REMAIN_W    = 18;
   localparam int OUT_W       = 18;
   localparam int DATA_W      = 16;
   localparam int PROD_W      = 25;
   localparam int BLEND_W     = 30;
   localparam int GAIN_W      = 16;
   localparam int STEP_W      = 5;
   localparam int PAN_MODE_W  = 3;
   localparam int PAN_LEVEL_W = 8;
   localparam int OPCODE_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_KEY_ON  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_KEY_OFF = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd4;

   // control register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_WHOLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_FRACTION = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAN_MODE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAN_LEVEL     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERPOLATE   = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   // pan modes
   localparam logic [PAN_MODE_W-1:0] PAN_CENTRE         = 3'd0;
   localparam logic [PAN_MODE_W-1:0] PAN_LEFT           = 3'd1;
   localparam logic [PAN_MODE_W-1:0] PAN_RIGHT          = 3'd2;
   localparam logic [PAN_MODE_W-1:0] PAN_CENTRE_ALT     = 3'd3;
   localparam logic [PAN_MODE_W-1:0] PAN_INV_CENTRE     = 3'd4;
   localparam logic [PAN_MODE_W-1:0] PAN_INV_LEFT       = 3'd5;
   localparam logic [PAN_MODE_W-1:0] PAN_INV_RIGHT      = 3'd6;
   localparam logic [PAN_MODE_W-1:0] PAN_INV_CENTRE_ALT = 3'd7;

   // pan settings handed to the pan stage
   typedef struct packed {
      logic [PAN_MODE_W-1:0]  mode;
      logic [PAN_LEVEL_W-1:0] level;
   } pan_cfg_type;

   // tick sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ0  = 5'b00010,
      ST_READ1  = 5'b00100,
      ST_BLEND  = 5'b01000,
      ST_OUTPUT = 5'b10000
   } state_type;

endpackage

[hw/rtl/pcm_voice_playback_unit.sv]
// top level of the pcm voice playback unit
//
// One 8-bit signed pcm voice with its own sample memory of 2^ADDR_BITS bytes.
// Request beats (req_) carry an opcode: write byte, key on, key off, stop or
// output tick. The request side is stalled while a tick is being worked on.
// Write, key on, key off, stop and unknown opcodes give no response. A tick
// that plays a sample yields a response beat (rsp_): two reads of the
// sample memory through its one read port, one after the other, feed a gain
// multiply, a blend multiply and a pan multiply, each registered. A tick on
// an idle voice gives no response; one on a voice whose remainder is at most
// one ends the note without a response. Responses sit in an output register;
// new requests are taken while a response waits. A tick that finishes while
// the receiver stalls holds in its last step until the output register frees.
// Control registers are written through csr_ (always ready); the user writes
// them only while the unit is idle, which the block does not enforce.
// Synchronous reset clears the voice state and sets the control registers to
// their defaults; sample memory contents are not cleared.
module pcm_voice_playback_unit #(
   parameter int ADDR_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [pcmv_pkg::OPCODE_W-1:0]            req_opcode,
   input  logic [pcmv_pkg::FIELD_ADDR_W-1:0]        req_mem_addr,
   input  logic [pcmv_pkg::BYTE_W-1:0]              req_mem_byte,
   input  logic [pcmv_pkg::FIELD_ADDR_W-1:0]        req_start_addr,
   input  logic [pcmv_pkg::LEN_W-1:0]               req_note_length,
   input  logic [pcmv_pkg::FIELD_ADDR_W-1:0]        req_loop_addr,
   input  logic [pcmv_pkg::LEN_W-1:0]               req_loop_length,
   input  logic [pcmv_pkg::FIELD_ADDR_W-1:0]        req_release_addr,
   input  logic [pcmv_pkg::LEN_W-1:0]               req_release_length,
   input  logic                                     req_loop_enable,
   input  logic                                     req_release_enable,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [pcmv_pkg::OUT_W-1:0]        rsp_left_sample,
   output logic signed [pcmv_pkg::OUT_W-1:0]        rsp_right_sample,
   output logic                                     rsp_voice_active,
   // control register write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pcmv_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [pcmv_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int MemDepth = 1 << ADDR_BITS;

   // control registers
   logic [pcmv_pkg::STEP_W-1:0]      step_whole_ff, step_whole_in;
   logic [pcmv_pkg::FRAC_BITS-1:0]   step_fraction_ff, step_fraction_in;
   logic [pcmv_pkg::GAIN_W-1:0]      gain_ff, gain_in;
   logic [pcmv_pkg::PAN_MODE_W-1:0]  pan_mode_ff, pan_mode_in;
   logic [pcmv_pkg::PAN_LEVEL_W-1:0] pan_level_ff, pan_level_in;
   logic                             interp_ff, interp_in;

   // voice state
   pcmv_pkg::state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]             pos_ff, pos_in;
   logic [pcmv_pkg::FRAC_BITS-1:0]   phase_ff, phase_in;
   logic signed [pcmv_pkg::REMAIN_W-1:0] remain_ff, remain_in;
   logic                             playing_ff, playing_in;
   logic                             released_ff, released_in;
   logic [pcmv_pkg::FIELD_ADDR_W-1:0] loop_addr_ff, loop_addr_in;
   logic [pcmv_pkg::LEN_W-1:0]       loop_len_ff, loop_len_in;
   logic [pcmv_pkg::FIELD_ADDR_W-1:0] rel_addr_ff, rel_addr_in;
   logic [pcmv_pkg::LEN_W-1:0]       rel_len_ff, rel_len_in;
   logic                             loop_en_ff, loop_en_in;
   logic                             rel_en_ff, rel_en_in;

   // datapath registers
   logic signed [pcmv_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pcmv_pkg::DATA_W-1:0] s0_ff, s0_in;
   logic signed [pcmv_pkg::DATA_W-1:0] data_ff, data_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [pcmv_pkg::OUT_W-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [pcmv_pkg::OUT_W-1:0]  rsp_right_ff, rsp_right_in;
   logic                               rsp_active_ff, rsp_active_in;

   // sample memory
   logic [pcmv_pkg::BYTE_W-1:0]        sample_mem [MemDepth];
   logic [pcmv_pkg::BYTE_W-1:0]        rd_byte_ff;
   logic [ADDR_BITS-1:0]               rd_addr;
   logic                               mem_we;

   // combinational helpers
   logic                               req_beat;
   logic                               out_free;
   logic signed [pcmv_pkg::DATA_W-1:0] scaled;
   logic signed [pcmv_pkg::LEN_W-1:0]  diff;
   logic signed [pcmv_pkg::BLEND_W-1:0] blend_prod;
   logic [pcmv_pkg::BLEND_W-1:0]       blend_acc;
   logic [pcmv_pkg::FRAC_BITS:0]       frac_sum;
   logic                               frac_carry;
   logic [ADDR_BITS-1:0]               pos_adv;
   logic signed [pcmv_pkg::REMAIN_W-1:0] remain_adv;
   logic signed [pcmv_pkg::OUT_W-1:0]  pan_left;
   logic signed [pcmv_pkg::OUT_W-1:0]  pan_right;
   pcmv_pkg::pan_cfg_type              pan_cfg;
   logic signed [pcmv_pkg::PROD_W-1:0] scale_biased;

   assign req_beat  = req_valid && !req_stall;
   assign req_stall = (state_ff != pcmv_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;
   assign rsp_voice_active = rsp_active_ff;

   // control register writes
   always_comb begin
      step_whole_in    = step_whole_ff;
      step_fraction_in = step_fraction_ff;
      gain_in          = gain_ff;
      pan_mode_in      = pan_mode_ff;
      pan_level_in     = pan_level_ff;
      interp_in        = interp_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pcmv_pkg::CSR_STEP_WHOLE:    step_whole_in    = csr_data[pcmv_pkg::STEP_W-1:0];
            pcmv_pkg::CSR_STEP_FRACTION: step_fraction_in = csr_data[pcmv_pkg::FRAC_BITS-1:0];
            pcmv_pkg::CSR_GAIN:          gain_in          = csr_data[pcmv_pkg::GAIN_W-1:0];
            pcmv_pkg::CSR_PAN_MODE:      pan_mode_in      = csr_data[pcmv_pkg::PAN_MODE_W-1:0];
            pcmv_pkg::CSR_PAN_LEVEL:     pan_level_in     = csr_data[pcmv_pkg::PAN_LEVEL_W-1:0];
            pcmv_pkg::CSR_INTERPOLATE:   interp_in        = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_whole_ff    <= '0;
         step_fraction_ff <= '0;
         gain_ff          <= pcmv_pkg::GAIN_RESET;
         pan_mode_ff      <= '0;
         pan_level_ff     <= '0;
         interp_ff        <= 1'b0;
      end else begin
         step_whole_ff    <= step_whole_in;
         step_fraction_ff <= step_fraction_in;
         gain_ff          <= gain_in;
         pan_mode_ff      <= pan_mode_in;
         pan_level_ff     <= pan_level_in;
         interp_ff        <= interp_in;
      end
   end

   // sample memory, byte writes and registered reads
   assign mem_we  = req_beat && (req_opcode == pcmv_pkg::OP_WRITE);
   assign rd_addr = (state_ff == pcmv_pkg::ST_READ0) ? pos_ff + ADDR_BITS'(1) : pos_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[ADDR_BITS'(req_mem_addr)] <= req_mem_byte;
      end
      rd_byte_ff <= sample_mem[rd_addr];
   end

   // gain product truncated toward zero
   assign scale_biased = prod_ff + (prod_ff[pcmv_pkg::PROD_W-1] ? 25'sd255 : 25'sd0);
   assign scaled       = scale_biased[pcmv_pkg::PROD_W-2:8];

   // blend: floor(s0 + (s1 - s0) * f / 4096)
   assign diff       = scaled - s0_ff;
   assign blend_prod = diff * $signed({1'b0, phase_ff});
   assign blend_acc  = {{2{s0_ff[pcmv_pkg::DATA_W-1]}}, s0_ff, {pcmv_pkg::FRAC_BITS{1'b0}}}
                       + blend_prod;

   // position advance
   assign frac_sum   = {1'b0, phase_ff} + {1'b0, step_fraction_ff};
   assign frac_carry = frac_sum[pcmv_pkg::FRAC_BITS];
   assign pos_adv    = pos_ff + ADDR_BITS'(frac_carry) + ADDR_BITS'(step_whole_ff);
   assign remain_adv = remain_ff - pcmv_pkg::REMAIN_W'(frac_carry)
                       - pcmv_pkg::REMAIN_W'(step_whole_ff);

   // pan stage
   assign pan_cfg.mode  = pan_mode_ff;
   assign pan_cfg.level = pan_level_ff;

   pcmv_pan u_pan (
      .data         (data_ff),
      .pan_cfg      (pan_cfg),
      .left_sample  (pan_left),
      .right_sample (pan_right)
   );

   // request handling and tick sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      remain_in     = remain_ff;
      playing_in    = playing_ff;
      released_in   = released_ff;
      loop_addr_in  = loop_addr_ff;
      loop_len_in   = loop_len_ff;
      rel_addr_in   = rel_addr_ff;
      rel_len_in    = rel_len_ff;
      loop_en_in    = loop_en_ff;
      rel_en_in     = rel_en_ff;
      prod_in       = prod_ff;
      s0_in         = s0_ff;
      data_in       = data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_active_in = rsp_active_ff;

      case (state_ff)
         pcmv_pkg::ST_IDLE: begin
            if (req_beat) begin
               case (req_opcode)
                  pcmv_pkg::OP_KEY_ON: begin
                     pos_in       = ADDR_BITS'(req_start_addr);
                     phase_in     = '0;
                     remain_in    = {1'b0, req_note_length};
                     loop_addr_in = req_loop_addr;
                     loop_len_in  = req_loop_length;
                     rel_addr_in  = req_release_addr;
                     rel_len_in   = req_release_length;
                     loop_en_in   = req_loop_enable;
                     rel_en_in    = req_release_enable;
                     playing_in   = 1'b1;
                     released_in  = 1'b0;
                  end
                  pcmv_pkg::OP_KEY_OFF: begin
                     if (rel_en_ff) begin
                        pos_in      = ADDR_BITS'(rel_addr_ff);
                        remain_in   = {1'b0, rel_len_ff};
                        released_in = 1'b1;
                     end else begin
                        playing_in = 1'b0;
                     end
                  end
                  pcmv_pkg::OP_STOP: begin
                     playing_in = 1'b0;
                  end
                  pcmv_pkg::OP_TICK: begin
                     // idle voice: nothing; short remainder: voice ends silently
                     if (playing_ff) begin
                        if (remain_ff <= 18'sd1) begin
                           playing_in = 1'b0;
                        end else begin
                           state_in = pcmv_pkg::ST_READ0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         pcmv_pkg::ST_READ0: begin
            // first byte back, scale it, next byte read under way
            prod_in  = $signed(rd_byte_ff) * $signed({1'b0, gain_ff});
            state_in = pcmv_pkg::ST_READ1;
         end
         pcmv_pkg::ST_READ1: begin
            s0_in    = scaled;
            prod_in  = $signed(rd_byte_ff) * $signed({1'b0, gain_ff});
            state_in = pcmv_pkg::ST_BLEND;
         end
         pcmv_pkg::ST_BLEND: begin
            data_in  = interp_ff ? blend_acc[pcmv_pkg::FRAC_BITS+pcmv_pkg::DATA_W-1:
                                             pcmv_pkg::FRAC_BITS]
                                 : s0_ff;
            state_in = pcmv_pkg::ST_OUTPUT;
         end
         pcmv_pkg::ST_OUTPUT: begin
            // commit the advance together with the response beat
            if (out_free) begin
               phase_in  = frac_sum[pcmv_pkg::FRAC_BITS-1:0];
               pos_in    = pos_adv;
               remain_in = remain_adv;
               rsp_active_in = 1'b1;
               if (remain_adv <= 18'sd1) begin
                  if (!loop_en_ff || released_ff) begin
                     playing_in    = 1'b0;
                     rsp_active_in = 1'b0;
                  end else begin
                     remain_in = {1'b0, loop_len_ff};
                     pos_in    = ADDR_BITS'(loop_addr_ff);
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_left_in  = pan_left;
               rsp_right_in = pan_right;
               state_in     = pcmv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcmv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcmv_pkg::ST_IDLE;
         pos_ff       <= '0;
         phase_ff     <= '0;
         remain_ff    <= '0;
         playing_ff   <= 1'b0;
         released_ff  <= 1'b0;
         loop_addr_ff <= '0;
         loop_len_ff  <= '0;
         rel_addr_ff  <= '0;
         rel_len_ff   <= '0;
         loop_en_ff   <= 1'b0;
         rel_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         playing_ff   <= playing_in;
         released_ff  <= released_in;
         loop_addr_ff <= loop_addr_in;
         loop_len_ff  <= loop_len_in;
         rel_addr_ff  <= rel_addr_in;
         rel_len_ff   <= rel_len_in;
         loop_en_ff   <= loop_en_in;
         rel_en_ff    <= rel_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      s0_ff         <= s0_in;
      data_ff       <= data_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_active_ff <= rsp_active_in;
   end

   // a new response only appears after the last tick step
   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pcmv_pkg::ST_OUTPUT))
      else $error("response raised outside the last tick step");

   // the play position holds while a tick is in flight
   a_pos_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcmv_pkg::ST_READ0 || state_ff == pcmv_pkg::ST_READ1 ||
       state_ff == pcmv_pkg::ST_BLEND) |=> $stable(pos_ff))
      else $error("play position moved during a tick");

   // a finished tick always leaves a response beat behind
   a_tick_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcmv_pkg::ST_OUTPUT && out_free) |=> rsp_valid_ff)
      else $error("tick finished without a response");

   // no sample byte is written while a tick reads the memory
   a_no_write_in_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pcmv_pkg::ST_IDLE) |-> !mem_we)
      else $error("sample write during a tick");

endmodule

[hw/rtl/pcmv_pan.sv]
// pan stage: side level scaling and left/right selection
module pcmv_pan (
   input  logic signed [pcmv_pkg::DATA_W-1:0] data,
   input  pcmv_pkg::pan_cfg_type              pan_cfg,
   output logic signed [pcmv_pkg::OUT_W-1:0]  left_sample,
   output logic signed [pcmv_pkg::OUT_W-1:0]  right_sample
);

   logic signed [pcmv_pkg::PROD_W-1:0] side_prod;
   logic signed [pcmv_pkg::PROD_W-1:0] side_biased;
   logic signed [pcmv_pkg::OUT_W-1:0]  side;
   logic signed [pcmv_pkg::OUT_W-1:0]  data_x;

   // side = data * level / 128, truncated toward zero
   assign side_prod   = data * $signed({1'b0, pan_cfg.level});
   assign side_biased = side_prod + (side_prod[pcmv_pkg::PROD_W-1] ? 25'sd127 : 25'sd0);
   assign side        = side_biased[pcmv_pkg::PROD_W-1:7];
   assign data_x      = data;

   // mode select, right side negated in the invert modes
   always_comb begin
      case (pan_cfg.mode) inside
         pcmv_pkg::PAN_LEFT: begin
            left_sample  = data_x;
            right_sample = side;
         end
         pcmv_pkg::PAN_RIGHT: begin
            left_sample  = side;
            right_sample = data_x;
         end
         pcmv_pkg::PAN_INV_CENTRE, pcmv_pkg::PAN_INV_CENTRE_ALT: begin
            left_sample  = data_x;
            right_sample = -data_x;
         end
         pcmv_pkg::PAN_INV_LEFT: begin
            left_sample  = data_x;
            right_sample = -side;
         end
         pcmv_pkg::PAN_INV_RIGHT: begin
            left_sample  = side;
            right_sample = -data_x;
         end
         default: begin
            left_sample  = data_x;
            right_sample = data_x;
         end
      endcase
   end

endmodule

[tb/testbench.sv]
// self-checking testbench for the pcm voice playback unit
`timescale 1ns / 1ps

module testbench;
   import pcmv_pkg::*;

   localparam int MEM_DEPTH    = 1 << FIELD_ADDR_W;
   localparam int FRAC_ONE     = 1 << FRAC_BITS;
   localparam int RESET_CYCLES = 9;
   localparam int IDLE_PCT     = 34;
   localparam int HOLD_CYCLES  = 120;
   localparam int SETTLE       = 16;
   localparam int DRAIN_LIMIT  = 100000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 105;
   localparam int TIMEOUT_NS   = 2000000;
   // two copies of the voice: one steered while planning, one stepped on beats
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   // one request beat
   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [FIELD_ADDR_W-1:0] mem_addr;
      logic [BYTE_W-1:0]       mem_byte;
      logic [FIELD_ADDR_W-1:0] start_addr;
      logic [LEN_W-1:0]        note_length;
      logic [FIELD_ADDR_W-1:0] loop_addr;
      logic [LEN_W-1:0]        loop_length;
      logic [FIELD_ADDR_W-1:0] release_addr;
      logic [LEN_W-1:0]        release_length;
      logic                    loop_enable;
      logic                    release_enable;
   } voice_req_t;

   // one mix bus contribution
   typedef struct packed {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
      logic                    active;
   } mix_out_t;

   // voice state plus control registers
   typedef struct {
      logic [FIELD_ADDR_W-1:0] position;
      logic [FRAC_BITS-1:0]    phase;
      int                      remaining;
      bit                      playing;
      bit                      released;
      logic [FIELD_ADDR_W-1:0] loop_addr;
      int                      loop_len;
      logic [FIELD_ADDR_W-1:0] rel_addr;
      int                      rel_len;
      bit                      loop_en;
      bit                      rel_en;
      logic [STEP_W-1:0]       step_whole;
      logic [FRAC_BITS-1:0]    step_fraction;
      logic [GAIN_W-1:0]       gain;
      logic [PAN_MODE_W-1:0]   pan_mode;
      logic [PAN_LEVEL_W-1:0]  pan_level;
      bit                      interpolate;
   } voice_model_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   voice_req_t              req_beat = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_left_sample;
   logic signed [OUT_W-1:0] rsp_right_sample;
   logic                    rsp_voice_active;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   voice_model_t            voice [0:1];
   logic [BYTE_W-1:0]       sample_copy [0:1][0:MEM_DEPTH-1];
   bit                      byte_written [0:MEM_DEPTH-1];

   voice_req_t              req_backlog [$];
   mix_out_t                mix_out_due [$];
   logic                    req_fire = 1'b0;
   int                      csr_writes = 0;
   int                      mismatches = 0;
   int                      results_seen = 0;
   bit                      calm = 1'b0;
   int                      hold_asks = 0;
   int                      hold_seen = 0;
   int                      hold_left = 0;

   pcm_voice_playback_unit u_top (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_opcode         (req_beat.opcode),
      .req_mem_addr       (req_beat.mem_addr),
      .req_mem_byte       (req_beat.mem_byte),
      .req_start_addr     (req_beat.start_addr),
      .req_note_length    (req_beat.note_length),
      .req_loop_addr      (req_beat.loop_addr),
      .req_loop_length    (req_beat.loop_length),
      .req_release_addr   (req_beat.release_addr),
      .req_release_length (req_beat.release_length),
      .req_loop_enable    (req_beat.loop_enable),
      .req_release_enable (req_beat.release_enable),
      .rsp_valid,
      .rsp_stall,
      .rsp_left_sample,
      .rsp_right_sample,
      .rsp_voice_active,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("** pcm_voice_playback_unit: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // voice predictor

   function automatic void voice_clear(int c);
      voice[c] = '{default: 0};
      voice[c].gain = GAIN_RESET;
   endfunction

   function automatic void voice_set_reg(int c, logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_STEP_WHOLE:    voice[c].step_whole = val[STEP_W-1:0];
         CSR_STEP_FRACTION: voice[c].step_fraction = val[FRAC_BITS-1:0];
         CSR_GAIN:          voice[c].gain = val[GAIN_W-1:0];
         CSR_PAN_MODE:      voice[c].pan_mode = val[PAN_MODE_W-1:0];
         CSR_PAN_LEVEL:     voice[c].pan_level = val[PAN_LEVEL_W-1:0];
         CSR_INTERPOLATE:   voice[c].interpolate = val[0];
         default: ;
      endcase
   endfunction

   // signed byte times Q8.8 gain, truncated toward zero
   function automatic int gained_byte(int c, logic [FIELD_ADDR_W-1:0] addr);
      int b;
      b = int'($signed(sample_copy[c][addr]));
      return (b * int'(voice[c].gain)) / 256;
   endfunction

   // move the play position on by one step; 1 when the note runs out
   function automatic bit step_position(int c);
      int phase_sum;
      phase_sum = int'(voice[c].phase) + int'(voice[c].step_fraction);
      if (phase_sum >= FRAC_ONE) begin
         phase_sum -= FRAC_ONE;
         voice[c].position = voice[c].position + 1'b1;
         voice[c].remaining--;
      end
      voice[c].phase = phase_sum[FRAC_BITS-1:0];
      voice[c].position = voice[c].position + voice[c].step_whole;
      voice[c].remaining -= int'(voice[c].step_whole);
      if (voice[c].remaining > 1) return 1'b0;
      if (!voice[c].loop_en || voice[c].released) return 1'b1;
      voice[c].remaining = voice[c].loop_len;
      voice[c].position = voice[c].loop_addr;
      return 1'b0;
   endfunction

   // apply one request beat; 1 when it yields a mix output
   function automatic bit voice_play(int c, voice_req_t r, output mix_out_t o);
      logic [FIELD_ADDR_W-1:0] next_addr;
      int data, s1, f, side, left, right;
      o = '0;
      if (r.opcode == OP_WRITE) begin
         sample_copy[c][r.mem_addr] = r.mem_byte;
         if (c == PLAN) byte_written[r.mem_addr] = 1'b1;
         return 1'b0;
      end
      if (r.opcode == OP_KEY_ON) begin
         voice[c].position = r.start_addr;
         voice[c].phase = '0;
         voice[c].remaining = int'(r.note_length);
         voice[c].loop_addr = r.loop_addr;
         voice[c].loop_len = int'(r.loop_length);
         voice[c].rel_addr = r.release_addr;
         voice[c].rel_len = int'(r.release_length);
         voice[c].loop_en = r.loop_enable;
         voice[c].rel_en = r.release_enable;
         voice[c].playing = 1'b1;
         voice[c].released = 1'b0;
         return 1'b0;
      end
      if (r.opcode == OP_KEY_OFF) begin
         if (voice[c].rel_en) begin
            voice[c].position = voice[c].rel_addr;
            voice[c].remaining = voice[c].rel_len;
            voice[c].released = 1'b1;
         end else begin
            voice[c].playing = 1'b0;
         end
         return 1'b0;
      end
      if (r.opcode == OP_STOP) begin
         voice[c].playing = 1'b0;
         return 1'b0;
      end
      if (r.opcode != OP_TICK || !voice[c].playing) return 1'b0;
      if (voice[c].remaining <= 1) begin
         voice[c].playing = 1'b0;
         return 1'b0;
      end

      data = gained_byte(c, voice[c].position);
      if (voice[c].interpolate) begin
         next_addr = voice[c].position + 1'b1;
         s1 = gained_byte(c, next_addr);
         f = int'(voice[c].phase);
         data = (data * (FRAC_ONE - f) + s1 * f) >>> FRAC_BITS;
      end
      side = (data * int'(voice[c].pan_level)) / 128;

      case (voice[c].pan_mode)
         PAN_LEFT:      begin left = data; right = side;  end
         PAN_RIGHT:     begin left = side; right = data;  end
         PAN_INV_CENTRE,
         PAN_INV_CENTRE_ALT: begin left = data; right = -data; end
         PAN_INV_LEFT:  begin left = data; right = -side; end
         PAN_INV_RIGHT: begin left = side; right = -data; end
         default:       begin left = data; right = data;  end
      endcase

      if (step_position(c)) voice[c].playing = 1'b0;
      o.left = left[OUT_W-1:0];
      o.right = right[OUT_W-1:0];
      o.active = voice[c].playing;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus building

   function automatic voice_req_t any_req(logic [OPCODE_W-1:0] op);
      voice_req_t r;
      r.opcode = op;
      r.mem_addr = FIELD_ADDR_W'($urandom);
      r.mem_byte = BYTE_W'($urandom);
      r.start_addr = FIELD_ADDR_W'($urandom);
      r.note_length = LEN_W'($urandom_range(MEM_DEPTH, 0));
      r.loop_addr = FIELD_ADDR_W'($urandom);
      r.loop_length = LEN_W'($urandom_range(MEM_DEPTH, 0));
      r.release_addr = FIELD_ADDR_W'($urandom);
      r.release_length = LEN_W'($urandom_range(MEM_DEPTH, 0));
      r.loop_enable = $urandom_range(1, 0);
      r.release_enable = $urandom_range(1, 0);
      return r;
   endfunction

   function automatic voice_req_t byte_write(logic [FIELD_ADDR_W-1:0] addr,
                                             logic [BYTE_W-1:0] val);
      voice_req_t r;
      r = any_req(OP_WRITE);
      r.mem_addr = addr;
      r.mem_byte = val;
      return r;
   endfunction

   function automatic voice_req_t note_on(logic [FIELD_ADDR_W-1:0] start,
                                          logic [LEN_W-1:0] len,
                                          logic [FIELD_ADDR_W-1:0] laddr,
                                          logic [LEN_W-1:0] llen,
                                          logic [FIELD_ADDR_W-1:0] raddr,
                                          logic [LEN_W-1:0] rlen,
                                          logic len_loop, logic len_rel);
      voice_req_t r;
      r = any_req(OP_KEY_ON);
      r.start_addr = start;
      r.note_length = len;
      r.loop_addr = laddr;
      r.loop_length = llen;
      r.release_addr = raddr;
      r.release_length = rlen;
      r.loop_enable = len_loop;
      r.release_enable = len_rel;
      return r;
   endfunction

   // mostly short regions, now and then the extremes
   function automatic logic [LEN_W-1:0] region_length(int typical_max);
      case ($urandom_range(11, 0))
         0: return LEN_W'($urandom_range(1, 0));
         1: return LEN_W'(MEM_DEPTH);
         2: return LEN_W'($urandom_range(MEM_DEPTH, 0));
         default: return LEN_W'($urandom_range(typical_max, 2));
      endcase
   endfunction

   // queue a beat; a tick first gets the bytes it will read written
   function automatic void queue_req(voice_req_t r);
      mix_out_t unused;
      logic [FIELD_ADDR_W-1:0] addr;
      voice_req_t fill;
      if (r.opcode == OP_TICK && voice[PLAN].playing && voice[PLAN].remaining > 1) begin
         for (int k = 0; k < 2; k++) begin
            addr = voice[PLAN].position + FIELD_ADDR_W'(k);
            if (!byte_written[addr]) begin
               fill = byte_write(addr, BYTE_W'($urandom));
               void'(voice_play(PLAN, fill, unused));
               req_backlog.push_back(fill);
            end
         end
      end
      void'(voice_play(PLAN, r, unused));
      req_backlog.push_back(r);
   endfunction

   // notes with random content and ticks, plus some noise
   function automatic void queue_random_notes(int target);
      int count, ticks, pick;
      logic [FIELD_ADDR_W-1:0] base;
      voice_req_t r;
      count = 0;
      while (count < target) begin
         if ($urandom_range(99, 0) < 80) begin
            base = ($urandom_range(7, 0) == 0) ?
                   FIELD_ADDR_W'(MEM_DEPTH - 1 - $urandom_range(15, 0)) :
                   FIELD_ADDR_W'($urandom);
            r = note_on(base, region_length(160),
                        ($urandom_range(1, 0) != 0) ?
                           base + FIELD_ADDR_W'($urandom_range(32, 0)) :
                           FIELD_ADDR_W'($urandom),
                        region_length(64), FIELD_ADDR_W'($urandom), region_length(64),
                        $urandom_range(99, 0) < 70, $urandom_range(1, 0));
            queue_req(r);
            count++;
            ticks = $urandom_range(40, 4);
            repeat (ticks) begin
               pick = $urandom_range(99, 0);
               if (pick < 85)
                  queue_req(any_req(OP_TICK));
               else if (pick < 91)
                  queue_req(any_req(OP_KEY_OFF));
               else if (pick < 94)
                  queue_req(any_req(OP_STOP));
               else if (pick < 98)
                  queue_req(byte_write(voice[PLAN].position, BYTE_W'($urandom)));
               else
                  queue_req(any_req(OP_WRITE));
               count++;
            end
         end else begin
            // noise, unknown opcodes among it
            r = any_req(OPCODE_W'($urandom));
            queue_req(r);
            if (r.opcode <= OP_TICK) count++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // register writes and phase boundaries

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      int done_before;
      @(negedge clock);
      done_before = csr_writes;
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      voice_set_reg(PLAN, idx, val);
      do @(negedge clock); while (csr_writes == done_before);
      csr_valid = 1'b0;
   endtask

   task automatic write_all_regs(int sw, int sf, int gn, int pm, int pl, int ip);
      write_reg(CSR_STEP_WHOLE, CSR_DATA_W'(sw));
      write_reg(CSR_STEP_FRACTION, CSR_DATA_W'(sf));
      write_reg(CSR_GAIN, CSR_DATA_W'(gn));
      write_reg(CSR_PAN_MODE, CSR_DATA_W'(pm));
      write_reg(CSR_PAN_LEVEL, CSR_DATA_W'(pl));
      write_reg(CSR_INTERPOLATE, CSR_DATA_W'(ip));
   endtask

   // wait for every queued beat and every due output, then let the unit settle
   task automatic drain();
      int waited;
      waited = 0;
      while ((req_backlog.size() != 0 || req_valid || mix_out_due.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request driver

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (req_backlog.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
            req_beat = req_backlog.pop_front();
            req_valid = 1'b1;
         end else begin
            req_valid = 1'b0;
         end
      end
   end

   // response back-pressure, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = !calm && ($urandom_range(99, 0) < IDLE_PCT);
      end
   end

   // step the checking copy on every accepted request and register beat
   always @(posedge clock) begin
      mix_out_t predicted;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         if (voice_play(CHECK, req_beat, predicted)) mix_out_due.push_back(predicted);
      end
      if (!reset && csr_valid && csr_ready) begin
         voice_set_reg(CHECK, csr_index, csr_data);
         csr_writes++;
      end
   end

   // response monitor
   always @(posedge clock) begin
      mix_out_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (mix_out_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d not expected: left %0d right %0d active %0b",
                        results_seen, rsp_left_sample, rsp_right_sample, rsp_voice_active);
         end else begin
            want = mix_out_due.pop_front();
            if (rsp_left_sample !== want.left || rsp_right_sample !== want.right ||
                rsp_voice_active !== want.active) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: left exp %0d got %0d, right exp %0d got %0d, ",
                            "active exp %0b got %0b"},
                           results_seen, want.left, rsp_left_sample, want.right,
                           rsp_right_sample, want.active, rsp_voice_active);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus sequence

   initial begin : stimulus
      int sw, sf, gn, pm, pl, ip;
      voice_clear(PLAN);
      voice_clear(CHECK);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corner cases, step of one and a half
      write_all_regs(1, FRAC_ONE / 2, GAIN_RESET, PAN_LEFT, 64, 1);
      queue_req(any_req(OP_TICK));                    // tick on an idle voice
      queue_req(any_req(OP_KEY_OFF));                 // key off, nothing latched
      for (int op = OP_TICK + 1; op < (1 << OPCODE_W); op++)
         queue_req(any_req(OPCODE_W'(op)));           // unknown opcodes
      queue_req(byte_write('1, 8'h7F));
      queue_req(byte_write('0, 8'h80));
      queue_req(byte_write(16'd1, 8'h00));
      queue_req(byte_write(16'd2, 8'hFF));
      // note across the top of memory
      queue_req(note_on('1, 17'd4, '0, '0, '0, '0, 1'b0, 1'b0));
      repeat (3) queue_req(any_req(OP_TICK));
      // one-byte and empty notes end at once
      queue_req(note_on('0, 17'd1, '0, '0, '0, '0, 1'b0, 1'b0));
      queue_req(any_req(OP_TICK));
      queue_req(note_on('0, 17'd0, '0, '0, '0, '0, 1'b1, 1'b0));
      queue_req(any_req(OP_TICK));
      // repeat region of a single byte
      queue_req(note_on('0, 17'd3, 16'd1, 17'd1, '0, '0, 1'b1, 1'b0));
      repeat (3) queue_req(any_req(OP_TICK));
      // full-length regions, release, then key off on a stopped voice
      queue_req(note_on('0, LEN_W'(MEM_DEPTH), '0, LEN_W'(MEM_DEPTH), '1,
                        LEN_W'(MEM_DEPTH), 1'b1, 1'b1));
      queue_req(any_req(OP_TICK));
      queue_req(any_req(OP_KEY_OFF));
      queue_req(any_req(OP_TICK));
      queue_req(any_req(OP_STOP));
      queue_req(any_req(OP_KEY_OFF));
      queue_req(any_req(OP_TICK));
      drain();

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         sw = ($urandom_range(4, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(3, 0);
         sf = $urandom_range(FRAC_ONE - 1, 0);
         gn = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(1023, 0);
         pm = (phase < 8) ? phase : $urandom_range(7, 0);
         pl = $urandom_range(255, 0);
         ip = $urandom_range(1, 0);
         if (phase == 1) begin
            sw = 31; sf = FRAC_ONE - 1; gn = 65535; pl = 255; ip = 1;
         end
         if (phase == 2) begin
            sw = 0; sf = 0; gn = 0; pl = 0; ip = 0;
         end
         write_all_regs(sw, sf, gn, pm, pl, ip);
         calm = (phase == 5);
         queue_random_notes(PHASE_ITEMS);
         // receiver holds off while the sender keeps offering
         if (phase == 3 || phase == 7) hold_asks++;
         drain();
         calm = 1'b0;
      end

      if (mismatches == 0 && mix_out_due.size() == 0)
         $display("** pcm_voice_playback_unit: PASSED **");
      else
         $display("** pcm_voice_playback_unit: FAILED **");
      $finish;
   end

endmodule
